FILE: hw/rtl/drov_pkg.sv
package drov_pkg;

   // List sizing
   localparam int MAX_REFERENCES = 64;
   localparam int IDX_W          = $clog2(MAX_REFERENCES);
   localparam int CNT_W          = $clog2(MAX_REFERENCES + 1);

   // Field widths
   localparam int OPCODE_W  = 2;
   localparam int ETA_W     = 13;
   localparam int PHI_W     = 12;
   localparam int PT_W      = 16;
   localparam int DR_W      = 12;
   localparam int DPT_REL_W = 16;

   // Derived datapath widths
   localparam int DR2_W   = 2 * ETA_W + 1;
   localparam int THR_W   = 2 * DR_W;
   localparam int PROD_W  = DPT_REL_W + PT_W;
   localparam int DPT_SH  = 8;

   // Half and full circle in phi units
   localparam logic [PHI_W-1:0] PHI_HALF = PHI_W'(1 << (PHI_W - 1));
   localparam logic [PHI_W:0]   PHI_FULL = (PHI_W + 1)'(1 << PHI_W);

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DELTA_R  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DPT_REL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EVENT_FILTER = 2'd2;

   localparam logic [DR_W-1:0]      MAX_DELTA_R_RST = 12'd7;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_START = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_TEST  = 2'd2;

   // One stored reference object
   typedef struct packed {
      logic signed [ETA_W-1:0] eta;
      logic [PHI_W-1:0]        phi;
      logic [PT_W-1:0]         pt;
   } ref_entry_type;

   // Controller to datapath
   typedef struct packed {
      logic start;
      logic load;
      logic test;
      logic issue;
      logic finish;
   } drov_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic list_empty;
      logic issue_last;
      logic pipe_busy;
   } drov_stat_type;

endpackage

FILE: hw/rtl/drov_ctrl.sv
module drov_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [drov_pkg::OPCODE_W-1:0]      req_opcode,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output drov_pkg::drov_cmd_type             cmd,
   input  drov_pkg::drov_stat_type            stat
);
   import drov_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_DRAIN = 4'b0100,
      S_FIN   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_beat;

   assign req_stall = (state_ff != S_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   // Sequence one beat: decode; a test scans the list, drains the compare pipe and delivers
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               case (req_opcode)
                  OP_START: cmd.start = 1'b1;
                  OP_LOAD:  cmd.load  = 1'b1;
                  OP_TEST: begin
                     cmd.test = 1'b1;
                     state_in = stat.list_empty ? S_FIN : S_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            cmd.issue = 1'b1;
            if (stat.issue_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (!stat.pipe_busy) state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold the result beat until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.finish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hw/rtl/drov_dp.sv
module drov_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  drov_pkg::drov_cmd_type                cmd,
   output drov_pkg::drov_stat_type               stat,
   input  logic signed [drov_pkg::ETA_W-1:0]     req_eta,
   input  logic [drov_pkg::PHI_W-1:0]            req_phi,
   input  logic [drov_pkg::PT_W-1:0]             req_pt,
   input  logic                                  req_last_candidate,
   input  logic                                  csr_we,
   input  logic [drov_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [drov_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic                                  rsp_keep,
   output logic                                  rsp_event_done,
   output logic                                  rsp_event_pass,
   output logic                                  rsp_overflow
);
   import drov_pkg::*;

   // Configuration registers
   logic [DR_W-1:0]      max_dr_ff;
   logic [DPT_REL_W-1:0] max_dpt_ff;
   logic                 filter_en_ff;

   // Event state
   logic [CNT_W-1:0] count_ff, count_in;
   logic             any_kept_ff, any_kept_in;
   logic             ovf_ff, ovf_in;
   logic             full;

   // Candidate under test
   logic signed [ETA_W-1:0] cand_eta_ff;
   logic [PHI_W-1:0]        cand_phi_ff;
   logic [PT_W-1:0]         cand_pt_ff;
   logic                    cand_last_ff;
   logic [THR_W-1:0]        thr_ff;

   // Scan and compare pipe
   ref_entry_type    mem [MAX_REFERENCES];
   ref_entry_type    rd_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             v1_ff, v2_ff, v3_ff;

   logic signed [ETA_W:0] de;
   logic [ETA_W:0]        de_abs;
   logic [PHI_W-1:0]      dp_raw;
   logic [ETA_W-1:0]      ade_ff, ade_in;
   logic [PHI_W-1:0]      dp_ff, dp_in;
   logic [PT_W-1:0]       dpt_ff, dpt_in, dpt2_ff;
   logic [PT_W-1:0]       rpt_ff;

   logic [2*ETA_W-1:0]    esq_ff;
   logic [2*PHI_W-1:0]    psq_ff;
   logic [PROD_W-1:0]     prod_ff;

   logic [DR2_W-1:0]      dr2;
   logic                  dr_ok, pt_ok;
   logic                  hit_ff, hit_in;
   logic                  keep;

   ref_entry_type         wr_entry;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_dr_ff    <= MAX_DELTA_R_RST;
         max_dpt_ff   <= '0;
         filter_en_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_DELTA_R:  max_dr_ff    <= csr_wdata[DR_W-1:0];
            CSR_MAX_DPT_REL:  max_dpt_ff   <= csr_wdata[DPT_REL_W-1:0];
            CSR_EVENT_FILTER: filter_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign full = (count_ff == CNT_W'(MAX_REFERENCES));
   assign keep = !hit_ff;

   // Event bookkeeping: clear on start, fill on load, accumulate on finish
   always_comb begin
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      any_kept_in = any_kept_ff;
      if (cmd.start) begin
         count_in    = '0;
         ovf_in      = 1'b0;
         any_kept_in = 1'b0;
      end else if (cmd.load) begin
         if (full) ovf_in = 1'b1;
         else      count_in = count_ff + CNT_W'(1);
      end else if (cmd.finish) begin
         any_kept_in = any_kept_ff | keep;
      end
   end

   assign wr_entry = '{eta: req_eta, phi: req_phi, pt: req_pt};

   // Reference list memory with registered read
   always_ff @(posedge clock) begin
      if (cmd.load && !full) mem[count_ff[IDX_W-1:0]] <= wr_entry;
      if (cmd.issue)         rd_ff <= mem[idx_ff];
   end

   // Scan index
   always_comb begin
      idx_in = idx_ff;
      if (cmd.test)       idx_in = '0;
      else if (cmd.issue) idx_in = idx_ff + IDX_W'(1);
   end

   assign stat.list_empty = (count_ff == '0);
   assign stat.issue_last = ({1'b0, idx_ff} + CNT_W'(1)) == count_ff;
   assign stat.pipe_busy  = v1_ff | v2_ff | v3_ff;

   // Latch the candidate and the squared cone radius
   always_ff @(posedge clock) begin
      if (cmd.test) begin
         cand_eta_ff  <= req_eta;
         cand_phi_ff  <= req_phi;
         cand_pt_ff   <= req_pt;
         cand_last_ff <= req_last_candidate;
         thr_ff       <= max_dr_ff * max_dr_ff;
      end
   end

   // Stage two: absolute differences, phi folded onto the half circle
   always_comb begin
      de     = {cand_eta_ff[ETA_W-1], cand_eta_ff} - {rd_ff.eta[ETA_W-1], rd_ff.eta};
      de_abs = de[ETA_W] ? (~de + (ETA_W + 1)'(1)) : de;
      ade_in = de_abs[ETA_W-1:0];
      dp_raw = cand_phi_ff - rd_ff.phi;
      dp_in  = (dp_raw > PHI_HALF) ? PHI_W'(PHI_FULL - {1'b0, dp_raw}) : dp_raw;
      dpt_in = (cand_pt_ff > rd_ff.pt) ? (cand_pt_ff - rd_ff.pt) : (rd_ff.pt - cand_pt_ff);
   end

   // Stage four: add squares, compare against both limits
   always_comb begin
      dr2    = {1'b0, esq_ff} + DR2_W'(psq_ff);
      dr_ok  = (max_dr_ff == '0) || (dr2 <= DR2_W'(thr_ff));
      pt_ok  = (max_dpt_ff == '0) || (PROD_W'({dpt2_ff, {DPT_SH{1'b0}}}) <= prod_ff);
      hit_in = cmd.test ? 1'b0 : (hit_ff | (v3_ff & dr_ok & pt_ok));
   end

   // Pipe payload
   always_ff @(posedge clock) begin
      ade_ff  <= ade_in;
      dp_ff   <= dp_in;
      dpt_ff  <= dpt_in;
      rpt_ff  <= rd_ff.pt;
      esq_ff  <= ade_ff * ade_ff;
      psq_ff  <= dp_ff * dp_ff;
      prod_ff <= max_dpt_ff * rpt_ff;
      dpt2_ff <= dpt_ff;
   end

   // Result beat fields
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_keep       <= keep;
         rsp_event_done <= cand_last_ff;
         rsp_event_pass <= cand_last_ff & (filter_en_ff ? (any_kept_ff | keep) : 1'b1);
         rsp_overflow   <= ovf_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
         any_kept_ff <= 1'b0;
         idx_ff      <= '0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         hit_ff      <= 1'b0;
      end else begin
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         any_kept_ff <= any_kept_in;
         idx_ff      <= idx_in;
         v1_ff       <= cmd.issue;
         v2_ff       <= v1_ff;
         v3_ff       <= v2_ff;
         hit_ff      <= hit_in;
      end
   end

endmodule

FILE: hw/rtl/delta_r_overlap_veto.sv
// Start and load beats leave the input open; the next beat is accepted right after.
// A test beat scans the stored list, one reference per cycle through a single
// memory read port and a four-stage compare pipe, and holds off new beats until
// its result beat is raised; an empty list skips the scan, a full list holds 64.
// Reset (synchronous, active high) empties the list, clears the event flags and
// loads the register defaults; list contents stay undefined until loaded.
module delta_r_overlap_veto (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [drov_pkg::OPCODE_W-1:0]         req_opcode,
   input  logic signed [drov_pkg::ETA_W-1:0]     req_eta,
   input  logic [drov_pkg::PHI_W-1:0]            req_phi,
   input  logic [drov_pkg::PT_W-1:0]             req_pt,
   input  logic                                  req_last_candidate,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_keep,
   output logic                                  rsp_event_done,
   output logic                                  rsp_event_pass,
   output logic                                  rsp_overflow,
   input  logic                                  csr_we,
   input  logic [drov_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [drov_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import drov_pkg::*;

   drov_cmd_type  cmd;
   drov_stat_type stat;

   drov_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .stat       (stat)
   );

   drov_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_eta            (req_eta),
      .req_phi            (req_phi),
      .req_pt             (req_pt),
      .req_last_candidate (req_last_candidate),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_keep           (rsp_keep),
      .rsp_event_done     (rsp_event_done),
      .rsp_event_pass     (rsp_event_pass),
      .rsp_overflow       (rsp_overflow)
   );

endmodule

FILE: hw/rtl/drov_checker.sv
module drov_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic [drov_pkg::OPCODE_W-1:0]         req_opcode,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic                                  rsp_keep,
   input logic                                  rsp_event_done,
   input logic                                  rsp_event_pass,
   input logic                                  rsp_overflow
);
   import drov_pkg::*;

   logic req_beat;
   assign req_beat = req_valid && !req_stall;

   // Stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid &&
         $stable({rsp_keep, rsp_event_done, rsp_event_pass, rsp_overflow}))
      else $error("stalled result beat changed");

   // Event pass only on the closing candidate
   a_pass_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_event_done |-> !rsp_event_pass)
      else $error("event pass without event done");

   // A test beat occupies the block
   a_test_busy: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_opcode == OP_TEST |=> req_stall)
      else $error("test beat did not stall input");

   // Start, load and other non-test beats leave the input open
   a_short_ops: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_opcode != OP_TEST |=> !req_stall)
      else $error("non-test beat stalled input");

   // A new result only appears at the end of a test beat
   a_rsp_from_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result beat without a scan");

endmodule

bind delta_r_overlap_veto drov_checker u_drov_checker (.*);
